### src/ssid_pkg.sv
// Package for the sorted set insert and delete unit.
// Holds the command and status codes, the beat structs and the cell control struct.
// Has no dependencies of its own.
`timescale 1ns / 1ps

package ssid_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_FULL     = 3'd3,
    ST_RANGE    = 3'd4
  } status_t;

  localparam int ValueW = 32;
  localparam int PosW   = 4;
  localparam int CountW = 5;
  localparam int ReadableCells = 1 << PosW;

  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [ValueW-1:0] value;
    logic [PosW-1:0]          position;
  } request_t;

  typedef struct packed {
    logic [2:0]               status;
    logic [CountW-1:0]        count;
    logic signed [ValueW-1:0] read_value;
  } result_t;

  typedef struct packed {
    logic                     ins_en;
    logic                     del_en;
    logic signed [ValueW-1:0] value;
    logic [PosW-1:0]          position;
  } ctrl_t;

endpackage

### src/ssid_cell.sv
// One compare-and-shift cell of the sorted chain, holding the entry of one rank.
// Depends on ssid_pkg for the control struct and widths.
`timescale 1ns / 1ps

module ssid_cell #(
  parameter int INDEX = 0
) (
  input  logic                              clk,
  input  ssid_pkg::ctrl_t                   ctrl,
  input  logic                              valid,
  input  logic                              left_lt,
  input  logic signed [ssid_pkg::ValueW-1:0] left_value,
  input  logic signed [ssid_pkg::ValueW-1:0] right_value,
  output logic signed [ssid_pkg::ValueW-1:0] entry,
  output logic                              lt,
  output logic                              eq,
  output logic signed [ssid_pkg::ValueW-1:0] rd
);

  localparam bit Readable = INDEX < ssid_pkg::ReadableCells;

  logic                               sel;
  logic signed [ssid_pkg::ValueW-1:0] entry_next;

  assign lt  = valid && (entry < ctrl.value);
  assign eq  = valid && (entry == ctrl.value);
  assign sel = Readable && valid &&
               (ctrl.position == ssid_pkg::PosW'(INDEX % ssid_pkg::ReadableCells));
  assign rd  = sel ? entry : '0;

  always_comb begin
    entry_next = entry;
    if (ctrl.ins_en && !lt) begin
      entry_next = left_lt ? ctrl.value : left_value;
    end else if (ctrl.del_en && !lt) begin
      entry_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

### src/sorted_set_insert_delete_unit.sv
// Top level of the sorted set insert and delete unit: a row of ssid_cell instances
// with the count, the command decode and the result register. Depends on ssid_pkg.
//
// Channel   Direction  Handshake          Payload
// request   in         start, busy        ssid_pkg::request_t
// result    out        done (one cycle)   ssid_pkg::result_t
//
// Every command is carried out as it is taken, as all cells compare and shift at once,
// so a command may follow in every cycle and busy stays low.
// The result appears with done in the cycle after the command beat.
// Reset clears the count; entries are written before they are read.
// The receiver cannot stall, so no result is ever held back.
`timescale 1ns / 1ps

module sorted_set_insert_delete_unit #(
  parameter int CAPACITY = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  ssid_pkg::request_t   request,
  output logic                 done,
  output ssid_pkg::result_t    result
);

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int NRD = (CAPACITY < ssid_pkg::ReadableCells) ? CAPACITY
                                                            : ssid_pkg::ReadableCells;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW+ssid_pkg::CountW-1:0] count_ext;

  logic signed [ssid_pkg::ValueW-1:0] entry [CAPACITY];
  logic signed [ssid_pkg::ValueW-1:0] rd    [CAPACITY];
  logic [CAPACITY-1:0] lt;
  logic [CAPACITY-1:0] eq;
  logic [CAPACITY-1:0] valid;

  ssid_pkg::ctrl_t ctrl;
  logic found;
  logic full;
  logic rd_hit;
  logic signed [ssid_pkg::ValueW-1:0] rd_value;
  ssid_pkg::result_t result_next;
  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign found  = |eq;
  assign full   = count >= CW'(CAPACITY);

  assign ctrl.value    = request.value;
  assign ctrl.position = request.position;
  assign ctrl.ins_en   = accept && (request.cmd == ssid_pkg::CMD_INSERT) && !found && !full;
  assign ctrl.del_en   = accept && (request.cmd == ssid_pkg::CMD_DELETE) && found;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                               left_lt;
    logic signed [ssid_pkg::ValueW-1:0] left_value;
    logic signed [ssid_pkg::ValueW-1:0] right_value;

    assign valid[i] = count > CW'(i);

    if (i == 0) begin : g_first
      assign left_lt    = 1'b1;
      assign left_value = '0;
    end else begin : g_mid
      assign left_lt    = lt[i-1];
      assign left_value = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_value = entry[i];
    end else begin : g_inner
      assign right_value = entry[i+1];
    end

    ssid_cell #(
      .INDEX(i)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .valid       (valid[i]),
      .left_lt     (left_lt),
      .left_value  (left_value),
      .right_value (right_value),
      .entry       (entry[i]),
      .lt          (lt[i]),
      .eq          (eq[i]),
      .rd          (rd[i])
    );
  end

  always_comb begin
    rd_value = '0;
    rd_hit   = 1'b0;
    for (int i = 0; i < NRD; i++) begin
      rd_value = rd_value | rd[i];
      rd_hit   = rd_hit | (valid[i] && (request.position == ssid_pkg::PosW'(i)));
    end
  end

  always_comb begin
    count_next = count;
    if (accept && (request.cmd == ssid_pkg::CMD_CLEAR)) begin
      count_next = '0;
    end else if (ctrl.ins_en) begin
      count_next = count + CW'(1);
    end else if (ctrl.del_en) begin
      count_next = count - CW'(1);
    end
  end

  assign count_ext = {{ssid_pkg::CountW{1'b0}}, count_next};

  always_comb begin
    result_next.status     = ssid_pkg::ST_OK;
    result_next.count      = count_ext[ssid_pkg::CountW-1:0];
    result_next.read_value = '0;
    unique case (request.cmd)
      ssid_pkg::CMD_INSERT: begin
        if (found) begin
          result_next.status = ssid_pkg::ST_DUP;
        end else if (full) begin
          result_next.status = ssid_pkg::ST_FULL;
        end
      end
      ssid_pkg::CMD_DELETE: begin
        if (!found) begin
          result_next.status = ssid_pkg::ST_NOTFOUND;
        end
      end
      ssid_pkg::CMD_CLEAR: begin
        result_next.status = ssid_pkg::ST_OK;
      end
      ssid_pkg::CMD_READ: begin
        if (rd_hit) begin
          result_next.read_value = rd_value;
        end else begin
          result_next.status = ssid_pkg::ST_RANGE;
        end
      end
      default: begin
        result_next.status = ssid_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  a_done_follows_beat: assert property (@(posedge clk) disable iff (rst)
    accept |=> done)
    else $error("command beat did not produce a result");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_full_means_capacity: assert property (@(posedge clk) disable iff (rst)
    done && (result.status == ssid_pkg::ST_FULL) |-> count == CW'(CAPACITY))
    else $error("full reported while the set has room");

  a_one_shift_at_most: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.ins_en && ctrl.del_en))
    else $error("insert and delete shift in the same cycle");
`endif

endmodule

### dv/tb.sv
// Self-checking testbench for sorted_set_insert_delete_unit: directed and random commands
// are checked against a sorted set predictor kept inside the bench.
// Depends on ssid_pkg and the unit under test; reads no files.
`timescale 1ns / 1ps

module tb;

  localparam int Capacity  = 16;
  localparam int IdleLimit = 200;

  logic               clk     = 1'b0;
  logic               rst     = 1'b1;
  logic               start   = 1'b0;
  ssid_pkg::request_t request = '0;
  logic               busy;
  logic               done;
  ssid_pkg::result_t  result;

  sorted_set_insert_delete_unit #(.CAPACITY(Capacity)) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result)
  );

  always #1 clk = ~clk;

  logic signed [ssid_pkg::ValueW-1:0] set_vals [Capacity];
  int                set_size = 0;
  ssid_pkg::result_t expected_results [$];
  bit                gaps_on = 1'b1;
  int                errors = 0;
  int                results_checked = 0;
  int                idle_cycles = 0;
  int                cmd_tally [4] = '{default: 0};
  int                status_tally [5] = '{default: 0};

  function automatic ssid_pkg::result_t apply_to_set(ssid_pkg::request_t rq);
    ssid_pkg::result_t res;
    int                r;
    bit                hit;
    res = '0;
    res.status = ssid_pkg::ST_OK;
    r = 0;
    while (r < set_size && set_vals[r] < rq.value) r++;
    hit = (r < set_size) && (set_vals[r] == rq.value);
    case (rq.cmd)
      ssid_pkg::CMD_INSERT: begin
        if (hit) begin
          res.status = ssid_pkg::ST_DUP;
        end else if (set_size >= Capacity) begin
          res.status = ssid_pkg::ST_FULL;
        end else begin
          for (int k = set_size; k > r; k--) set_vals[k] = set_vals[k-1];
          set_vals[r] = rq.value;
          set_size++;
        end
      end
      ssid_pkg::CMD_DELETE: begin
        if (!hit) begin
          res.status = ssid_pkg::ST_NOTFOUND;
        end else begin
          for (int k = r; k + 1 < set_size; k++) set_vals[k] = set_vals[k+1];
          set_size--;
        end
      end
      ssid_pkg::CMD_CLEAR: begin
        set_size = 0;
      end
      default: begin
        if (rq.position < set_size) res.read_value = set_vals[rq.position];
        else res.status = ssid_pkg::ST_RANGE;
      end
    endcase
    res.count = ssid_pkg::CountW'(set_size);
    return res;
  endfunction

  function automatic ssid_pkg::request_t beat(ssid_pkg::cmd_t c,
                                              logic signed [ssid_pkg::ValueW-1:0] v,
                                              logic [ssid_pkg::PosW-1:0] p);
    ssid_pkg::request_t rq;
    rq.cmd = c;
    rq.value = v;
    rq.position = p;
    return rq;
  endfunction

  function automatic logic signed [ssid_pkg::ValueW-1:0] fresh_value();
    logic signed [ssid_pkg::ValueW-1:0] v;
    bit taken;
    do begin
      v = $urandom;
      taken = 1'b0;
      for (int i = 0; i < set_size; i++) if (set_vals[i] == v) taken = 1'b1;
    end while (taken);
    return v;
  endfunction

  // Deletes and reads mostly aim at stored values and valid ranks, inserts less often; a few are pure noise.
  function automatic ssid_pkg::request_t random_cmd(int ins_pct, int del_pct);
    ssid_pkg::request_t rq;
    int                 pick;
    rq.cmd = ssid_pkg::CMD_READ;
    rq.value = $urandom;
    rq.position = ssid_pkg::PosW'($urandom);
    if ($urandom_range(0, 99) < 8) begin
      rq.cmd = 2'($urandom);
      return rq;
    end
    pick = $urandom_range(0, 99);
    if (pick < ins_pct) rq.cmd = ssid_pkg::CMD_INSERT;
    else if (pick < ins_pct + del_pct) rq.cmd = ssid_pkg::CMD_DELETE;
    else if (pick < 98) rq.cmd = ssid_pkg::CMD_READ;
    else rq.cmd = ssid_pkg::CMD_CLEAR;
    pick = $urandom_range(0, 9);
    case (rq.cmd)
      ssid_pkg::CMD_INSERT, ssid_pkg::CMD_DELETE: begin
        if (set_size > 0 && pick < (rq.cmd == ssid_pkg::CMD_INSERT ? 2 : 7)) begin
          rq.value = set_vals[$urandom_range(0, set_size - 1)];
        end else if (pick == 9) begin
          rq.value = $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 3)
                                          : 32'h80000000 + $urandom_range(0, 3);
        end
      end
      ssid_pkg::CMD_READ: begin
        if (set_size > 0 && pick < 8) begin
          rq.position = ssid_pkg::PosW'($urandom_range(0, set_size - 1));
        end
      end
      default: begin
      end
    endcase
    return rq;
  endfunction

  task automatic send_cmd(input ssid_pkg::request_t rq);
    ssid_pkg::result_t res;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 7)) begin
        @(negedge clk);
        start <= 1'b0;
        request <= random_cmd(50, 30);
      end
    end
    @(negedge clk);
    start <= 1'b1;
    request <= rq;
    do @(posedge clk); while (busy);
    res = apply_to_set(rq);
    expected_results.push_back(res);
    cmd_tally[rq.cmd]++;
    status_tally[res.status]++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_set();
    send_cmd(beat(ssid_pkg::CMD_READ, 0, 4'd0));
    send_cmd(beat(ssid_pkg::CMD_DELETE, 7, 4'd0));
    send_cmd(beat(ssid_pkg::CMD_INSERT, 32'sh7fffffff, 4'd0));
    send_cmd(beat(ssid_pkg::CMD_INSERT, 32'sh80000000, 4'd0));
    send_cmd(beat(ssid_pkg::CMD_INSERT, 0, 4'd0));
    send_cmd(beat(ssid_pkg::CMD_INSERT, 0, 4'd0));
    send_cmd(beat(ssid_pkg::CMD_READ, 0, 4'd0));
    send_cmd(beat(ssid_pkg::CMD_READ, 0, 4'd1));
    send_cmd(beat(ssid_pkg::CMD_READ, 0, 4'd2));
    send_cmd(beat(ssid_pkg::CMD_READ, 0, 4'd3));
    send_cmd(beat(ssid_pkg::CMD_READ, 0, 4'd15));
    send_cmd(beat(ssid_pkg::CMD_DELETE, 32'sh80000000, 4'd0));
  endtask

  task automatic test_capacity();
    while (set_size < Capacity) send_cmd(beat(ssid_pkg::CMD_INSERT, fresh_value(), 4'd0));
    send_cmd(beat(ssid_pkg::CMD_INSERT, fresh_value(), 4'd0));
    send_cmd(beat(ssid_pkg::CMD_INSERT, set_vals[7], 4'd0));
    send_cmd(beat(ssid_pkg::CMD_READ, 0, 4'd15));
    send_cmd(beat(ssid_pkg::CMD_DELETE, set_vals[Capacity-1], 4'd0));
    send_cmd(beat(ssid_pkg::CMD_CLEAR, 0, 4'd0));
    send_cmd(beat(ssid_pkg::CMD_READ, 0, 4'd0));
  endtask

  task automatic test_random_mix(int n, int ins_pct, int del_pct);
    repeat (n) send_cmd(random_cmd(ins_pct, del_pct));
  endtask

  always @(posedge clk) begin
    ssid_pkg::result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no command waiting: status %0d count %0d",
               result.status, result.count);
        errors++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (result.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, result.status);
          errors++;
        end
        if (result.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, result.count);
          errors++;
        end
        if (result.read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, result.read_value);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb: watchdog expired with %0d results outstanding", expected_results.size());
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_set();
    test_capacity();
    drain_results();
    test_random_mix(600, 65, 20);
    drain_results();
    test_random_mix(400, 20, 60);
    drain_results();
    gaps_on = 1'b0;
    test_random_mix(500, 40, 35);
    drain_results();
    repeat (4) @(posedge clk);
    $display("tb: %0d inserts, %0d deletes, %0d clears, %0d reads; %0d results checked",
             cmd_tally[ssid_pkg::CMD_INSERT], cmd_tally[ssid_pkg::CMD_DELETE],
             cmd_tally[ssid_pkg::CMD_CLEAR], cmd_tally[ssid_pkg::CMD_READ],
             results_checked);
    $display("tb: ok %0d, duplicate %0d, not found %0d, full %0d, out of range %0d",
             status_tally[ssid_pkg::ST_OK], status_tally[ssid_pkg::ST_DUP],
             status_tally[ssid_pkg::ST_NOTFOUND], status_tally[ssid_pkg::ST_FULL],
             status_tally[ssid_pkg::ST_RANGE]);
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
